[src/sps_pkg.sv]
// shared constants for the segmented prime sieve
// default sizes, fixed port widths and the small numeric constants
// no dependencies
package sps_pkg;

   // default sizes
   localparam int unsigned SEG_SPAN_DEF          = 65536;
   localparam int unsigned LIMIT_BITS_DEF        = 32;
   localparam int unsigned PRIME_TABLE_DEPTH_DEF = 8192;

   // fixed port widths
   localparam int unsigned LIMIT_REG_W = 32;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned COUNT_W     = 28;

   // the only even prime and the first odd candidate
   localparam int unsigned FIRST_PRIME = 2;
   localparam int unsigned FIRST_ODD   = 3;

endpackage

[src/segmented_prime_sieve.sv]
// segmented prime sieve top level: sequencer, base bitmap, segment bitmap, prime table
// depends on sps_pkg (sizes, widths, constants)
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_restart
//   rsp     | out       | rsp_valid/rsp_stall | rsp_prime_value, rsp_found, rsp_last_prime,
//           |           |                     | rsp_prime_count
//   csr     | in        | csr_valid/csr_ready | csr_data (upper limit)
//
// one transaction at a time; finding a prime scans each odd candidate through ST_SCAN and
// ST_SCAN_WAIT, writes each crossed-out mark in ST_SV_MARK, and refills the segment bitmap
// once per segment. the first pull of a run also computes the integer square root.
// after reset and after each restart the base bitmap is refilled while req_stall is high.
// a finished result waits in the output register while rsp_stall is high.
module segmented_prime_sieve #(
   parameter int unsigned SEG_SPAN          = sps_pkg::SEG_SPAN_DEF,
   parameter int unsigned LIMIT_BITS        = sps_pkg::LIMIT_BITS_DEF,
   parameter int unsigned PRIME_TABLE_DEPTH = sps_pkg::PRIME_TABLE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sps_pkg::VALUE_W-1:0]     rsp_prime_value,
   output logic                            rsp_found,
   output logic                            rsp_last_prime,
   output logic [sps_pkg::COUNT_W-1:0]     rsp_prime_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sps_pkg::LIMIT_REG_W-1:0] csr_data
);

   localparam int unsigned BASE_W     = (LIMIT_BITS + 1) / 2;
   localparam int unsigned BASE_DEPTH = 1 << BASE_W;
   localparam int unsigned SEG_W      = $clog2(SEG_SPAN);
   localparam int unsigned TBL_W      = $clog2(PRIME_TABLE_DEPTH);
   localparam int unsigned NUM_W      = ((LIMIT_BITS > SEG_W) ? LIMIT_BITS : SEG_W) + 1;
   localparam int unsigned SQ_W       = 2 * (BASE_W + 1);
   localparam int unsigned CMP_W      = (SQ_W > NUM_W) ? SQ_W : NUM_W;
   localparam int unsigned OFF_W      = (SEG_W > BASE_W + 1) ? SEG_W : BASE_W + 1;
   localparam int unsigned J2_W       = OFF_W + 1;
   localparam int unsigned CLR_W      = (BASE_W > SEG_W) ? BASE_W : SEG_W;
   localparam int unsigned BIT_W      = $clog2(BASE_W);

   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [BASE_W-1:0] prm;
   } tbl_entry_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLR_BASE, ST_START, ST_SQRT, ST_EMIT, ST_NP_ENTRY, ST_NO_CHECK,
      ST_SEG_CLR, ST_BC_CHECK, ST_BC_READ, ST_BC_MARK, ST_AC_CHECK, ST_AC_READ,
      ST_SV_READ, ST_SV_LOAD, ST_SV_MARK, ST_SCAN, ST_SCAN_WAIT, ST_DELIVER
   } state_type;

   // registers
   state_type                       state_ff, state_in;
   logic                            ret_emit_ff, ret_emit_in;
   logic                            then_start_ff, then_start_in;
   logic [sps_pkg::LIMIT_REG_W-1:0] upper_limit_ff, upper_limit_in;
   logic [LIMIT_BITS-1:0]           limit_ff, limit_in;
   logic [BASE_W-1:0]               root_ff, root_in;
   logic [BIT_W-1:0]                bit_ff, bit_in;
   logic                            started_ff, started_in;
   logic                            two_sent_ff, two_sent_in;
   logic                            seg_loaded_ff, seg_loaded_in;
   logic                            sieve_done_ff, sieve_done_in;
   logic                            ahead_valid_ff, ahead_valid_in;
   logic [NUM_W-1:0]                ahead_ff, ahead_in;
   logic [NUM_W-1:0]                emit_v_ff, emit_v_in;
   logic                            found_res_ff, found_res_in;
   logic [NUM_W-1:0]                base_ff, base_in;
   logic [NUM_W-1:0]                high_ff, high_in;
   logic [NUM_W-1:0]                cand_ff, cand_in;
   logic [NUM_W-1:0]                cprev_ff, cprev_in;
   logic [BASE_W:0]                 bc_ff, bc_in;
   logic [BASE_W:0]                 ac_ff, ac_in;
   logic [SQ_W-1:0]                 sq_ff, sq_in;
   logic [BASE_W:0]                 j_ff, j_in;
   logic [TBL_W:0]                  fill_ff, fill_in;
   logic [TBL_W:0]                  t_ff, t_in;
   logic [J2_W-1:0]                 j2_ff, j2_in;
   logic [BASE_W-1:0]               p_ff, p_in;
   logic [CLR_W-1:0]                clr_ff, clr_in;
   logic [sps_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sps_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_last_ff, rsp_last_in;
   logic [sps_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // memory ports
   logic                base_map [BASE_DEPTH];
   logic                base_we, base_wd, base_re, base_rd_ff;
   logic [BASE_W-1:0]   base_wa, base_ra;
   logic                seg_map [SEG_SPAN];
   logic                seg_we, seg_wd, seg_re, seg_rd_ff;
   logic [SEG_W-1:0]    seg_wa, seg_ra;
   tbl_entry_type       tbl_mem [PRIME_TABLE_DEPTH];
   logic                tbl_we, tbl_re;
   logic [TBL_W-1:0]    tbl_wa, tbl_ra;
   tbl_entry_type       tbl_wd, tbl_rd_ff;

   // helpers
   logic              req_accept, out_free;
   logic [BASE_W-1:0] trial;
   logic [BASE_W:0]   mul_a;
   logic [SQ_W-1:0]   mul_ext;
   logic [CMP_W-1:0]  cmp_rhs;
   logic              sq_le;
   logic [NUM_W-1:0]  lim_ext, seg_end;
   logic              np_done, np_ok;
   logic [NUM_W-1:0]  np_val;

   assign req_accept      = req_valid && !req_stall;
   assign req_stall       = (state_ff != ST_IDLE);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_last_prime  = rsp_last_ff;
   assign rsp_prime_count = rsp_count_ff;

   // shared squarer for the square root and both cursors
   assign trial   = root_ff | (BASE_W'(1) << bit_ff);
   assign mul_a   = (state_ff == ST_SQRT) ? {1'b0, trial} :
                    (state_ff == ST_AC_CHECK) ? ac_ff : bc_ff;
   assign mul_ext = SQ_W'(mul_a);
   assign sq_in   = mul_ext * mul_ext;
   assign cmp_rhs = (state_ff == ST_SQRT) ? CMP_W'(limit_ff) : CMP_W'(high_ff);
   assign sq_le   = CMP_W'(sq_in) <= cmp_rhs;

   // segment bounds
   assign lim_ext = NUM_W'(limit_ff);
   assign seg_end = NUM_W'(base_ff + NUM_W'(SEG_SPAN - 1));

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      ret_emit_in    = ret_emit_ff;
      then_start_in  = then_start_ff;
      upper_limit_in = upper_limit_ff;
      limit_in       = limit_ff;
      root_in        = root_ff;
      bit_in         = bit_ff;
      started_in     = started_ff;
      two_sent_in    = two_sent_ff;
      seg_loaded_in  = seg_loaded_ff;
      sieve_done_in  = sieve_done_ff;
      ahead_valid_in = ahead_valid_ff;
      ahead_in       = ahead_ff;
      emit_v_in      = emit_v_ff;
      found_res_in   = found_res_ff;
      base_in        = base_ff;
      high_in        = high_ff;
      cand_in        = cand_ff;
      cprev_in       = cprev_ff;
      bc_in          = bc_ff;
      ac_in          = ac_ff;
      j_in           = j_ff;
      fill_in        = fill_ff;
      t_in           = t_ff;
      j2_in          = j2_ff;
      p_in           = p_ff;
      clr_in         = clr_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_value_in   = rsp_value_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_count_in   = rsp_count_ff;
      base_we = 1'b0; base_wa = '0; base_wd = 1'b0; base_re = 1'b0; base_ra = '0;
      seg_we  = 1'b0; seg_wa  = '0; seg_wd  = 1'b0; seg_re  = 1'b0; seg_ra  = '0;
      tbl_we  = 1'b0; tbl_wa  = '0; tbl_wd  = '0;   tbl_re  = 1'b0; tbl_ra  = '0;
      np_done = 1'b0; np_ok = 1'b0; np_val = '0;

      // configuration write
      if (csr_valid) begin
         upper_limit_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_restart) begin
                  fill_in       = '0;
                  base_in       = '0;
                  cand_in       = NUM_W'(sps_pkg::FIRST_ODD);
                  bc_in         = (BASE_W + 1)'(sps_pkg::FIRST_ODD);
                  ac_in         = (BASE_W + 1)'(sps_pkg::FIRST_ODD);
                  count_in      = '0;
                  two_sent_in   = 1'b0;
                  started_in    = 1'b0;
                  seg_loaded_in = 1'b0;
                  sieve_done_in = 1'b0;
                  ahead_valid_in = 1'b0;
                  clr_in        = '0;
                  then_start_in = 1'b1;
                  state_in      = ST_CLR_BASE;
               end else if (!started_ff) begin
                  state_in = ST_START;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         // refill base bitmap with ones
         ST_CLR_BASE: begin
            base_we = 1'b1;
            base_wa = clr_ff[BASE_W-1:0];
            base_wd = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(BASE_DEPTH - 1)) begin
               state_in = then_start_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            limit_in = LIMIT_BITS'(upper_limit_ff);
            root_in  = '0;
            bit_in   = BIT_W'(BASE_W - 1);
            state_in = ST_SQRT;
         end
         // integer square root, one bit per cycle
         ST_SQRT: begin
            if (sq_le) begin
               root_in = trial;
            end
            if (bit_ff == '0) begin
               started_in  = 1'b1;
               ret_emit_in = 1'b0;
               state_in    = ST_NP_ENTRY;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (ahead_valid_ff) begin
               emit_v_in    = ahead_ff;
               found_res_in = 1'b1;
               ret_emit_in  = 1'b1;
               state_in     = ST_NP_ENTRY;
            end else begin
               found_res_in = 1'b0;
               state_in     = ST_DELIVER;
            end
         end
         ST_NP_ENTRY: begin
            if (lim_ext < NUM_W'(sps_pkg::FIRST_PRIME)) begin
               np_done = 1'b1;
            end else if (!two_sent_ff) begin
               two_sent_in = 1'b1;
               np_done     = 1'b1;
               np_ok       = 1'b1;
               np_val      = NUM_W'(sps_pkg::FIRST_PRIME);
            end else begin
               state_in = ST_NO_CHECK;
            end
         end
         ST_NO_CHECK: begin
            if (sieve_done_ff) begin
               np_done = 1'b1;
            end else if (!seg_loaded_ff) begin
               if (base_ff > lim_ext) begin
                  sieve_done_in = 1'b1;
                  np_done       = 1'b1;
               end else begin
                  high_in  = (seg_end < lim_ext) ? seg_end : lim_ext;
                  clr_in   = '0;
                  state_in = ST_SEG_CLR;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         // refill segment bitmap with ones
         ST_SEG_CLR: begin
            seg_we = 1'b1;
            seg_wa = clr_ff[SEG_W-1:0];
            seg_wd = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(SEG_SPAN - 1)) begin
               state_in = ST_BC_CHECK;
            end
         end
         // sieve base primes up to the segment top
         ST_BC_CHECK: begin
            if (!bc_ff[BASE_W] && sq_le) begin
               base_re  = 1'b1;
               base_ra  = bc_ff[BASE_W-1:0];
               state_in = ST_BC_READ;
            end else begin
               state_in = ST_AC_CHECK;
            end
         end
         ST_BC_READ: begin
            if (base_rd_ff && (CMP_W'(sq_ff) <= CMP_W'(root_ff))) begin
               j_in     = sq_ff[BASE_W:0];
               state_in = ST_BC_MARK;
            end else begin
               bc_in    = bc_ff + (BASE_W + 1)'(2);
               state_in = ST_BC_CHECK;
            end
         end
         ST_BC_MARK: begin
            if (j_ff <= {1'b0, root_ff}) begin
               base_we = 1'b1;
               base_wa = j_ff[BASE_W-1:0];
               base_wd = 1'b0;
               j_in    = j_ff + bc_ff;
            end else begin
               bc_in    = bc_ff + (BASE_W + 1)'(2);
               state_in = ST_BC_CHECK;
            end
         end
         // append newly needed sieving primes
         ST_AC_CHECK: begin
            if (!ac_ff[BASE_W] && sq_le) begin
               base_re  = 1'b1;
               base_ra  = ac_ff[BASE_W-1:0];
               state_in = ST_AC_READ;
            end else begin
               t_in     = '0;
               state_in = ST_SV_READ;
            end
         end
         ST_AC_READ: begin
            if (base_rd_ff && (fill_ff < (TBL_W + 1)'(PRIME_TABLE_DEPTH))) begin
               tbl_we     = 1'b1;
               tbl_wa     = fill_ff[TBL_W-1:0];
               tbl_wd.prm = ac_ff[BASE_W-1:0];
               tbl_wd.off = OFF_W'(CMP_W'(sq_ff) - CMP_W'(base_ff));
               fill_in    = fill_ff + 1'b1;
            end
            ac_in    = ac_ff + (BASE_W + 1)'(2);
            state_in = ST_AC_CHECK;
         end
         // cross out odd multiples of each table prime
         ST_SV_READ: begin
            if (t_ff < fill_ff) begin
               tbl_re   = 1'b1;
               tbl_ra   = t_ff[TBL_W-1:0];
               state_in = ST_SV_LOAD;
            end else begin
               seg_loaded_in = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SV_LOAD: begin
            p_in     = tbl_rd_ff.prm;
            j2_in    = J2_W'(tbl_rd_ff.off);
            state_in = ST_SV_MARK;
         end
         ST_SV_MARK: begin
            if (j2_ff < J2_W'(SEG_SPAN)) begin
               seg_we = 1'b1;
               seg_wa = j2_ff[SEG_W-1:0];
               seg_wd = 1'b0;
               j2_in  = j2_ff + J2_W'({p_ff, 1'b0});
            end else begin
               tbl_we     = 1'b1;
               tbl_wa     = t_ff[TBL_W-1:0];
               tbl_wd.prm = p_ff;
               tbl_wd.off = OFF_W'(j2_ff - J2_W'(SEG_SPAN));
               t_in       = t_ff + 1'b1;
               state_in   = ST_SV_READ;
            end
         end
         // scan odd survivors
         ST_SCAN: begin
            if (cand_ff <= high_ff) begin
               seg_re   = 1'b1;
               seg_ra   = SEG_W'(cand_ff - base_ff);
               cprev_in = cand_ff;
               cand_in  = cand_ff + NUM_W'(2);
               state_in = ST_SCAN_WAIT;
            end else begin
               base_in       = base_ff + NUM_W'(SEG_SPAN);
               seg_loaded_in = 1'b0;
               state_in      = ST_NO_CHECK;
            end
         end
         ST_SCAN_WAIT: begin
            if (seg_rd_ff) begin
               np_done = 1'b1;
               np_ok   = 1'b1;
               np_val  = cprev_ff;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (found_res_ff) begin
                  rsp_value_in = sps_pkg::VALUE_W'(emit_v_ff);
                  rsp_found_in = 1'b1;
                  rsp_last_in  = !ahead_valid_ff;
                  rsp_count_in = count_ff + 1'b1;
                  count_in     = count_ff + 1'b1;
               end else begin
                  rsp_value_in = '0;
                  rsp_found_in = 1'b0;
                  rsp_last_in  = 1'b0;
                  rsp_count_in = count_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // return from the next-prime search
      if (np_done) begin
         ahead_valid_in = np_ok;
         if (np_ok) begin
            ahead_in = np_val;
         end
         state_in = ret_emit_ff ? ST_DELIVER : ST_EMIT;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLR_BASE;
         then_start_ff  <= 1'b0;
         ret_emit_ff    <= 1'b0;
         upper_limit_ff <= '0;
         limit_ff       <= '0;
         started_ff     <= 1'b0;
         two_sent_ff    <= 1'b0;
         seg_loaded_ff  <= 1'b0;
         sieve_done_ff  <= 1'b0;
         ahead_valid_ff <= 1'b0;
         found_res_ff   <= 1'b0;
         base_ff        <= '0;
         cand_ff        <= NUM_W'(sps_pkg::FIRST_ODD);
         bc_ff          <= (BASE_W + 1)'(sps_pkg::FIRST_ODD);
         ac_ff          <= (BASE_W + 1)'(sps_pkg::FIRST_ODD);
         fill_ff        <= '0;
         t_ff           <= '0;
         clr_ff         <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         then_start_ff  <= then_start_in;
         ret_emit_ff    <= ret_emit_in;
         upper_limit_ff <= upper_limit_in;
         limit_ff       <= limit_in;
         started_ff     <= started_in;
         two_sent_ff    <= two_sent_in;
         seg_loaded_ff  <= seg_loaded_in;
         sieve_done_ff  <= sieve_done_in;
         ahead_valid_ff <= ahead_valid_in;
         found_res_ff   <= found_res_in;
         base_ff        <= base_in;
         cand_ff        <= cand_in;
         bc_ff          <= bc_in;
         ac_ff          <= ac_in;
         fill_ff        <= fill_in;
         t_ff           <= t_in;
         clr_ff         <= clr_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      ahead_ff     <= ahead_in;
      emit_v_ff    <= emit_v_in;
      high_ff      <= high_in;
      cprev_ff     <= cprev_in;
      sq_ff        <= sq_in;
      j_ff         <= j_in;
      j2_ff        <= j2_in;
      p_ff         <= p_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   // base bitmap
   always_ff @(posedge clock) begin
      if (base_we) begin
         base_map[base_wa] <= base_wd;
      end
      if (base_re) begin
         base_rd_ff <= base_map[base_ra];
      end
   end

   // segment bitmap
   always_ff @(posedge clock) begin
      if (seg_we) begin
         seg_map[seg_wa] <= seg_wd;
      end
      if (seg_re) begin
         seg_rd_ff <= seg_map[seg_ra];
      end
   end

   // prime table with next-multiple offsets
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_wa] <= tbl_wd;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_ra];
      end
   end

   // table never overfills
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (TBL_W + 1)'(PRIME_TABLE_DEPTH))
      else $error("prime table fill beyond depth");

   // scanned candidate lies inside the loaded segment
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_WAIT) |-> (cprev_ff >= base_ff) && (cprev_ff <= high_ff))
      else $error("scan candidate outside segment");

   // scan only visits odd candidates
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> cand_ff[0])
      else $error("even scan candidate");

   // a delivered result shows up on the output next cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not presented");

   // a found prime is never zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> (rsp_value_ff != '0))
      else $error("found flag with zero value");

endmodule
